[rtl/ascii_integer_field_scanner_defines.svh]
// Assertion macros for the ASCII integer field scanner checker.
`ifndef ASCII_INTEGER_FIELD_SCANNER_DEFINES_SVH
`define ASCII_INTEGER_FIELD_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AIFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aifs checker: assertion failed");

// Next-cycle implication, disabled during reset.
`define AIFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aifs checker: assertion failed");

// Next-cycle implication, active through reset.
`define AIFS_ASSERT_RST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("aifs checker: assertion failed");

`endif

[rtl/aifs_pkg.sv]
// Package: types, codes and constants of the ASCII integer field scanner.
package aifs_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int VALUE_BITS      = 64;
  localparam int CHAR_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;
  localparam int WIDTH_W         = 8;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX,
    BASE_AUTO
  } base_t;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SIZE = 2'd2;

  localparam logic [1:0] SIZE_16 = 2'd0;
  localparam logic [1:0] SIZE_32 = 2'd1;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_EIGHT = 8'h38;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CASE_BIT_CLEAR = 8'hDF;
  localparam logic [3:0]        HEX_LETTER_BASE = 4'd10;

  typedef struct packed {
    base_t              base_mode;
    logic [WIDTH_W-1:0] max_width;
    logic [1:0]         result_size;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic               negate;
    logic               digits_seen;
    logic [WIDTH_W-1:0] width_left;
    base_t              active_base;
  } ctl_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  matched;
    logic                  char_taken;
    logic                  hit_end;
  } res_t;

  localparam ctl_t CTL_CLEAR = '{
    phase:       PH_SKIP,
    negate:      1'b0,
    digits_seen: 1'b0,
    width_left:  '0,
    active_base: BASE_DEC
  };

endpackage

[rtl/aifs_if.sv]
// Channel interfaces of the ASCII integer field scanner.
interface aifs_feed_if import aifs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              at_end;
  modport source(output valid, character, at_end, input ready);
  modport sink(input valid, character, at_end, output ready);
endinterface

interface aifs_result_if import aifs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  matched;
  logic                  char_taken;
  logic                  hit_end;
  modport source(output valid, value, matched, char_taken, hit_end, input ready);
  modport sink(input valid, value, matched, char_taken, hit_end, output ready);
endinterface

interface aifs_cfg_if import aifs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/aifs_cfg.sv]
// Configuration register file of the ASCII integer field scanner.
module aifs_cfg import aifs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  aifs_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.base_mode   <= BASE_DEC;
      regs.max_width   <= '0;
      regs.result_size <= SIZE_32;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE_MODE:   regs.base_mode   <= base_t'(cfg.data[1:0]);
        REG_MAX_WIDTH:   regs.max_width   <= cfg.data;
        REG_RESULT_SIZE: regs.result_size <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/aifs_step.sv]
// Per-character scan step: next field state and the result it completes.
module aifs_step import aifs_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  ctl_t                   st,
  input  logic [VALUE_WIDTH-1:0] acc,
  input  cfg_t                   regs,
  input  logic [CHAR_W-1:0]      character,
  input  logic                   at_end,
  output ctl_t                   st_next,
  output logic [VALUE_WIDTH-1:0] acc_next,
  output logic                   emit,
  output res_t                   res
);

  function automatic logic is_white(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // {valid, value}
  function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c, input base_t b);
    logic [CHAR_W-1:0] u;
    logic [CHAR_W-1:0] dd;
    logic [CHAR_W-1:0] ud;
    u  = c & CASE_BIT_CLEAR;
    dd = c - CH_ZERO;
    ud = u - CH_UP_A;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      if ((b == BASE_OCT) && (c >= CH_EIGHT)) return 5'b0;
      return {1'b1, dd[3:0]};
    end
    if ((b == BASE_HEX) && (u >= CH_UP_A) && (u <= CH_UP_F))
      return {1'b1, ud[3:0] + HEX_LETTER_BASE};
    return 5'b0;
  endfunction

  phase_t                 ph;
  base_t                  ab;
  logic                   neg;
  logic                   ds;
  logic [WIDTH_W-1:0]     wl;
  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] dext;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_BITS-1:0]  v64;
  logic [4:0]             dg;
  logic                   fin;
  logic                   tk;
  logic                   he;
  logic                   go_pre;
  logic                   go_dig;

  always_comb begin
    ph     = st.phase;
    ab     = st.active_base;
    neg    = st.negate;
    ds     = st.digits_seen;
    wl     = st.width_left;
    a      = acc;
    fin    = 1'b0;
    tk     = 1'b0;
    he     = 1'b0;
    go_pre = 1'b0;
    go_dig = 1'b0;
    dg     = 5'b0;
    dext   = '0;

    if (at_end) begin
      if (ph == PH_ZERO) ds = 1'b1;
      fin = 1'b1;
      he  = 1'b1;
    end else begin
      unique case (ph)
        PH_SKIP: begin
          if (!is_white(character)) begin
            ab  = regs.base_mode;
            wl  = regs.max_width;
            a   = '0;
            neg = 1'b0;
            ds  = 1'b0;
            if ((character == CH_MINUS) || (character == CH_PLUS)) begin
              neg = (character == CH_MINUS);
              ph  = PH_PREFIX;
              if (wl != '0) begin
                wl = wl - 1'b1;
                if (wl == '0) begin
                  fin = 1'b1;
                  tk  = 1'b1;
                end
              end
            end else begin
              go_pre = 1'b1;
            end
          end
        end
        PH_PREFIX: go_pre = 1'b1;
        PH_ZERO: begin
          if ((character == CH_LO_X) || (character == CH_UP_X)) begin
            ab = BASE_HEX;
            ph = PH_DIGITS;
          end else begin
            // lone leading zero becomes a digit
            ds = 1'b1;
            if (ab == BASE_AUTO) begin
              ab     = BASE_OCT;
              go_dig = 1'b1;
            end else begin
              if (wl != '0) begin
                wl = wl - 1'b1;
                if (wl == '0) fin = 1'b1;
              end
              go_dig = !fin;
            end
          end
        end
        default: go_dig = 1'b1;
      endcase

      if (go_pre) begin
        if (((ab == BASE_HEX) || (ab == BASE_AUTO)) && (character == CH_ZERO)) begin
          ph = PH_ZERO;
        end else begin
          if (ab == BASE_AUTO) ab = BASE_DEC;
          go_dig = 1'b1;
        end
      end

      if (go_dig) begin
        dg   = digit_of(character, ab);
        dext = VALUE_WIDTH'(dg[3:0]);
        if (!dg[4]) begin
          fin = 1'b1;
        end else begin
          if (ab == BASE_HEX)      a = (a << 4) + dext;
          else if (ab == BASE_OCT) a = (a << 3) + dext;
          else                     a = (a << 3) + (a << 1) + dext;
          ds = 1'b1;
          ph = PH_DIGITS;
          if (wl != '0) begin
            wl = wl - 1'b1;
            if (wl == '0) begin
              fin = 1'b1;
              tk  = 1'b1;
            end
          end
        end
      end
    end

    v   = ds ? (neg ? (~a + 1'b1) : a) : '0;
    v64 = VALUE_BITS'(v);
    case (regs.result_size)
      SIZE_16: res.value = v64 & VALUE_BITS'(16'hFFFF);
      SIZE_32: res.value = v64 & VALUE_BITS'(32'hFFFF_FFFF);
      default: res.value = v64;
    endcase
    res.matched    = ds;
    res.char_taken = tk;
    res.hit_end    = he;
    emit           = fin;

    if (fin) begin
      st_next  = CTL_CLEAR;
      acc_next = '0;
    end else begin
      st_next.phase       = ph;
      st_next.negate      = neg;
      st_next.digits_seen = ds;
      st_next.width_left  = wl;
      st_next.active_base = ab;
      acc_next            = a;
    end
  end

endmodule

[rtl/ascii_integer_field_scanner.sv]
// Top level of the ASCII integer field scanner.
// Takes one character item per cycle, unless an item that ends a field is held
// back by a waiting result, and emits one result item when the field ends
// (non-digit, width limit or end of input). A character is held in the input
// register, where the combinational scan step computes the next field state;
// the state registers and, when the field ends, the result register are loaded
// as the item advances, and the result then stays valid until it is taken. One
// item per cycle sustained while no waiting result blocks the input, limited by
// the state update loop. While a result waits, the input keeps taking items that
// do not end a field; an item that ends one waits in the input register until
// the result is taken. Configuration is taken one write per cycle.
module ascii_integer_field_scanner import aifs_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  aifs_feed_if.sink      feed,
  aifs_result_if.source  result,
  aifs_cfg_if.sink       cfg
);

  cfg_t                   regs;
  logic                   feed_v;
  logic [CHAR_W-1:0]      feed_char;
  logic                   feed_end;
  ctl_t                   st;
  ctl_t                   st_next;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic                   emit;
  res_t                   res_next;
  res_t                   res_q;
  logic                   res_v;
  logic                   advance;

  aifs_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  aifs_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
    .st        (st),
    .acc       (acc),
    .regs      (regs),
    .character (feed_char),
    .at_end    (feed_end),
    .st_next   (st_next),
    .acc_next  (acc_next),
    .emit      (emit),
    .res       (res_next)
  );

  assign advance    = feed_v && (!emit || !res_v || result.ready);
  assign feed.ready = !feed_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_v <= 1'b0;
    end else if (feed.ready) begin
      feed_v <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.ready && feed.valid) begin
      feed_char <= feed.character;
      feed_end  <= feed.at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= CTL_CLEAR;
      acc <= '0;
    end else if (advance) begin
      st  <= st_next;
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (advance && emit) begin
      res_v <= 1'b1;
    end else if (result.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) res_q <= res_next;
  end

  assign result.valid      = res_v;
  assign result.value      = res_q.value;
  assign result.matched    = res_q.matched;
  assign result.char_taken = res_q.char_taken;
  assign result.hit_end    = res_q.hit_end;

endmodule

[rtl/aifs_checker.sv]
// Port checker of the ASCII integer field scanner, with its bind.
`include "ascii_integer_field_scanner_defines.svh"

module aifs_checker import aifs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [VALUE_BITS-1:0] res_value,
  input logic                  res_matched,
  input logic                  res_char_taken,
  input logic                  res_hit_end
);

  logic [VALUE_BITS+2:0] res_bits;

  assign res_bits = {res_value, res_matched, res_char_taken, res_hit_end};

  `AIFS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_bits))
  `AIFS_ASSERT_IMP(a_unmatched_zero, res_valid && !res_matched, res_value == '0)
  `AIFS_ASSERT_IMP(a_end_not_taken, res_valid && res_hit_end, !res_char_taken)
  `AIFS_ASSERT_RST_NXT(a_reset_empty, rst, !res_valid)

endmodule

bind ascii_integer_field_scanner aifs_checker u_aifs_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_value      (result.value),
  .res_matched    (result.matched),
  .res_char_taken (result.char_taken),
  .res_hit_end    (result.hit_end)
);
